// ===== hdl/key_value_map_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// key_value_map_table_unit_defines
// Assertion macros used by the key/value table controller.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_MAP_TABLE_UNIT_DEFINES_SVH
`define KEY_VALUE_MAP_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset.
`define KVMT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvmt assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define KVMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvmt assertion failed");

`else

`define KVMT_ASSERT_NOW(lbl, ante, cons)
`define KVMT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/kvmt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvmt_pkg
// Shared widths, defaults and codes of the key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package kvmt_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;
  localparam int STATUS_W  = 2;

  localparam logic OP_SET    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/key_value_map_table_unit.sv =====
// ----------------------------------------------------------------------------
// key_value_map_table_unit: key/value table scanned through one shared comparator
// Keys are compared in slot order; a set hit or a miss ends in the result, a lookup
// hit first reads the value RAM. One item at a time: busy until the result is out. Sync
// reset empties the table (RAM not cleared); out_valid strobes, receiver can't stall.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_map_table_unit #(
  parameter int DEPTH = kvmt_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic [kvmt_pkg::KEY_W-1:0]    in_key,
  input  wire logic [kvmt_pkg::VAL_W-1:0]    in_value_in,
  output logic                               out_valid,
  output logic [kvmt_pkg::STATUS_W-1:0]      out_status,
  output logic [kvmt_pkg::VAL_W-1:0]         out_value_out
);

  localparam int AW = $clog2(DEPTH);

  logic                         key_we;
  logic                         val_we;
  logic [AW-1:0]                waddr;
  logic [AW-1:0]                key_raddr;
  logic [AW-1:0]                val_raddr;
  logic [kvmt_pkg::KEY_W-1:0]   key_wdata;
  logic [kvmt_pkg::VAL_W-1:0]   val_wdata;
  logic [kvmt_pkg::KEY_W-1:0]   key_rdata;
  logic [kvmt_pkg::VAL_W-1:0]   val_rdata;

  kvmt_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_key        (in_key),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .key_we        (key_we),
    .key_raddr     (key_raddr),
    .key_rdata     (key_rdata),
    .val_we        (val_we),
    .val_raddr     (val_raddr),
    .val_rdata     (val_rdata),
    .waddr         (waddr),
    .key_wdata     (key_wdata),
    .val_wdata     (val_wdata)
  );

  kvmt_ram #(
    .DEPTH (DEPTH),
    .WIDTH (kvmt_pkg::KEY_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  kvmt_ram #(
    .DEPTH (DEPTH),
    .WIDTH (kvmt_pkg::VAL_W)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/kvmt_ram.sv =====
// ----------------------------------------------------------------------------
// kvmt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kvmt_ram #(
  parameter int DEPTH = kvmt_pkg::DEPTH_DEF,
  parameter int WIDTH = kvmt_pkg::KEY_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/kvmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvmt_ctrl
// Sequencer: scans stored keys one per cycle through a single comparator,
// then updates, appends or reads back the value, or reports a miss or a full table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_value_map_table_unit_defines.svh"

module kvmt_ctrl #(
  parameter int DEPTH = kvmt_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic [kvmt_pkg::KEY_W-1:0]    in_key,
  input  wire logic [kvmt_pkg::VAL_W-1:0]    in_value_in,
  output logic                               out_valid,
  output logic [kvmt_pkg::STATUS_W-1:0]      out_status,
  output logic [kvmt_pkg::VAL_W-1:0]         out_value_out,
  // key memory
  output logic                               key_we,
  output logic [AW-1:0]                      key_raddr,
  input  wire logic [kvmt_pkg::KEY_W-1:0]    key_rdata,
  // value memory
  output logic                               val_we,
  output logic [AW-1:0]                      val_raddr,
  input  wire logic [kvmt_pkg::VAL_W-1:0]    val_rdata,
  // shared write address and data
  output logic [AW-1:0]                      waddr,
  output logic [kvmt_pkg::KEY_W-1:0]         key_wdata,
  output logic [kvmt_pkg::VAL_W-1:0]         val_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_VAL
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  fill_r, fill_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]                  cmp_idx_r, cmp_idx_nxt;
  logic                           op_r, op_nxt;
  logic [kvmt_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [kvmt_pkg::VAL_W-1:0]     val_r, val_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [kvmt_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [kvmt_pkg::VAL_W-1:0]     out_value_r, out_value_nxt;
  logic                           hit;
  logic                           has_room;

  // key_rdata belongs to the read issued in the previous cycle (cmp_idx_r)
  assign hit      = cmp_vld_r && (key_rdata == key_r);
  assign has_room = (fill_r < CW'(DEPTH));

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    key_we         = 1'b0;
    val_we         = 1'b0;
    waddr          = cmp_idx_r;
    key_raddr      = idx_r[AW-1:0];
    val_raddr      = cmp_idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = in_op;
          key_nxt     = in_key;
          val_nxt     = in_value_in;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          cmp_vld_nxt = 1'b0;
          if (op_r == kvmt_pkg::OP_SET) begin
            val_we         = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = kvmt_pkg::STATUS_OK;
            out_value_nxt  = '0;
            state_nxt      = S_IDLE;
          end else begin
            // value read issued at cmp_idx_r this cycle
            state_nxt = S_VAL;
          end
        end else if (idx_r < fill_r) begin
          idx_nxt     = idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[AW-1:0];
        end else begin
          // all valid entries compared, key absent
          cmp_vld_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          state_nxt     = S_IDLE;
          if (op_r == kvmt_pkg::OP_SET) begin
            if (has_room) begin
              key_we         = 1'b1;
              val_we         = 1'b1;
              waddr          = fill_r[AW-1:0];
              fill_nxt       = fill_r + CW'(1);
              out_status_nxt = kvmt_pkg::STATUS_OK;
            end else begin
              out_status_nxt = kvmt_pkg::STATUS_FULL;
            end
          end else begin
            out_status_nxt = kvmt_pkg::STATUS_MISS;
          end
        end
      end
      S_VAL: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = kvmt_pkg::STATUS_OK;
        out_value_nxt  = val_rdata;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign key_wdata     = key_r;
  assign val_wdata     = val_r;

  `KVMT_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CW'(DEPTH))
  `KVMT_ASSERT_NOW(a_append_room, key_we, has_room && !hit)
  `KVMT_ASSERT_NXT(a_start_busy, start && !busy, busy && !out_valid_r)
  `KVMT_ASSERT_NXT(a_single_strobe, out_valid_r, !out_valid_r)
  `KVMT_ASSERT_NOW(a_zero_on_fail, out_valid_r && out_status_r != kvmt_pkg::STATUS_OK, out_value_r == '0)

endmodule

`default_nettype wire

// ===== sim/tb_key_value_map_table_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_value_map_table_unit
// Self-checking bench for the key/value table. A short directed sequence
// covers empty-table misses, extreme keys and values, and overwrites. A random
// sequence then fills the table past capacity and mixes sets and lookups of
// stored, neighboring and fresh keys. A scoreboard keeps its own copy of the
// map, predicts each result at the input transfer, and checks results in order.
// ----------------------------------------------------------------------------
module tb_key_value_map_table_unit;

  localparam int MAP_DEPTH  = kvmt_pkg::DEPTH_DEF;
  localparam int RAND_ITEMS = 1800;
  localparam int QUIET_TAIL = 300;

  typedef struct packed {
    logic [kvmt_pkg::STATUS_W-1:0] status;
    logic [kvmt_pkg::VAL_W-1:0]    value;
  } kv_result_t;

  class kv_scoreboard;
    logic [kvmt_pkg::KEY_W-1:0] map_keys [MAP_DEPTH];
    logic [kvmt_pkg::VAL_W-1:0] map_vals [MAP_DEPTH];
    int                         fill_count;
    kv_result_t                 pending [$];
    int                         mismatches;

    function new();
      fill_count = 0;
      mismatches = 0;
    endfunction

    function int find_slot(logic [kvmt_pkg::KEY_W-1:0] key);
      for (int i = 0; i < fill_count; i++) begin
        if (map_keys[i] == key) return i;
      end
      return -1;
    endfunction

    // Applies one accepted request to the map and queues its result.
    function void note_request(logic op, logic [kvmt_pkg::KEY_W-1:0] key,
                               logic [kvmt_pkg::VAL_W-1:0] value);
      kv_result_t res;
      int         slot;
      slot       = find_slot(key);
      res.status = kvmt_pkg::STATUS_OK;
      res.value  = '0;
      if (op == kvmt_pkg::OP_SET) begin
        if (slot >= 0) begin
          map_vals[slot] = value;
        end else if (fill_count < MAP_DEPTH) begin
          map_keys[fill_count] = key;
          map_vals[fill_count] = value;
          fill_count++;
        end else begin
          res.status = kvmt_pkg::STATUS_FULL;
        end
      end else begin
        if (slot >= 0) res.value = map_vals[slot];
        else res.status = kvmt_pkg::STATUS_MISS;
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [kvmt_pkg::STATUS_W-1:0] status,
                               logic [kvmt_pkg::VAL_W-1:0] value);
      kv_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: status %0d value %h",
                   $time, status, value);
      end else begin
        want = pending.pop_front();
        if (status !== want.status || value !== want.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: status exp %0d got %0d, value exp %h got %h",
                     $time, want.status, status, want.value, value);
        end
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_op;
  logic [kvmt_pkg::KEY_W-1:0]    in_key;
  logic [kvmt_pkg::VAL_W-1:0]    in_value_in;
  logic                          out_valid;
  logic [kvmt_pkg::STATUS_W-1:0] out_status;
  logic [kvmt_pkg::VAL_W-1:0]    out_value_out;

  kv_scoreboard sb = new();
  bit           quiet;

  key_value_map_table_unit #(
    .DEPTH(MAP_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_key       (in_key),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_value_out(out_value_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_value_out);
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [kvmt_pkg::KEY_W-1:0] stored_key();
    if (sb.fill_count == 0) return rand_word();
    return sb.map_keys[$urandom_range(sb.fill_count - 1)];
  endfunction

  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start       = 1'b0;
      in_op       = 1'($urandom_range(1));
      in_key      = rand_word();
      in_value_in = rand_word();
    end
  endtask

  // Holds start high until the transfer; start stays high into the next item unless idle cycles are inserted.
  task automatic send_item(input logic op, input logic [kvmt_pkg::KEY_W-1:0] key,
                           input logic [kvmt_pkg::VAL_W-1:0] value);
    @(negedge clk);
    start       = 1'b1;
    in_op       = op;
    in_key      = key;
    in_value_in = value;
    do @(posedge clk); while (busy);
    sb.note_request(op, key, value);
    if (!quiet && $urandom_range(3) == 0) idle_input($urandom_range(1, 4));
  endtask

  initial begin
    int                         sel;
    logic [kvmt_pkg::KEY_W-1:0] key;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_op       = kvmt_pkg::OP_SET;
    in_key      = '0;
    in_value_in = '0;
    quiet       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, extreme keys and values, overwrite, near misses
    send_item(kvmt_pkg::OP_LOOKUP, '0, '1);
    send_item(kvmt_pkg::OP_LOOKUP, '1, '0);
    send_item(kvmt_pkg::OP_SET,    '0, '1);
    send_item(kvmt_pkg::OP_SET,    '1, '0);
    send_item(kvmt_pkg::OP_LOOKUP, '0, '0);
    send_item(kvmt_pkg::OP_LOOKUP, '1, '1);
    send_item(kvmt_pkg::OP_LOOKUP, 64'd1, '0);
    send_item(kvmt_pkg::OP_SET,    '0, 64'h5555_5555_5555_5555);
    send_item(kvmt_pkg::OP_LOOKUP, '0, '1);
    send_item(kvmt_pkg::OP_SET,    64'h8000_0000_0000_0000, 64'h1);
    send_item(kvmt_pkg::OP_LOOKUP, 64'h7fff_ffff_ffff_ffff, '0);
    send_item(kvmt_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, '0);
    send_item(kvmt_pkg::OP_SET,    64'h8000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(kvmt_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h1234);
    send_item(kvmt_pkg::OP_LOOKUP, 64'hffff_ffff_ffff_fffe, '0);

    // random: fills the table early, then runs mostly against a full table
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      sel = $urandom_range(99);
      if (sel < 35) begin
        key = ($urandom_range(7) == 0) ? 64'($urandom_range(15)) : rand_word();
        send_item(kvmt_pkg::OP_SET, key, rand_word());
      end else if (sel < 50) begin
        send_item(kvmt_pkg::OP_SET, stored_key(), rand_word());
      end else if (sel < 80) begin
        send_item(kvmt_pkg::OP_LOOKUP, stored_key(), rand_word());
      end else if (sel < 90) begin
        key = stored_key() ^ (64'd1 << $urandom_range(63));
        send_item(kvmt_pkg::OP_LOOKUP, key, rand_word());
      end else begin
        send_item(kvmt_pkg::OP_LOOKUP, rand_word(), rand_word());
      end
    end
    @(negedge clk);
    start = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (MAP_DEPTH + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
